// ===== hdl/moving_average_edge_modes_macros.svh =====
// ----------------------------------------------------------------------------
// moving_average_edge_modes_macros.svh
// Assertion macros shared by the moving average block. The macros expand to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_EDGE_MODES_MACROS_SVH
`define MOVING_AVERAGE_EDGE_MODES_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold in every cycle outside reset
`define MAE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition in one cycle implies a consequence in the next
`define MAE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MAE_ASSERT(lbl, prop, msg)
`define MAE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/mae_pkg.sv =====
// ----------------------------------------------------------------------------
// mae_pkg
// Widths, codes and shared types of the moving average block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mae_pkg;

  localparam int MAX_WINDOW  = 1024;
  localparam int PTR_W       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WIN_W       = $clog2(MAX_WINDOW + 1);
  localparam int SAMPLE_W    = 32;
  localparam int TIME_W      = 64;
  localparam int DATA_W      = SAMPLE_W + TIME_W;  // already whole bytes
  localparam int SUM_W       = 64;
  localparam int PROD_W      = WIN_W + 1 + SAMPLE_W;
  localparam int QUO_W       = SAMPLE_W + 1;
  localparam int CNT_W       = $clog2(QUO_W);
  localparam int QUEUE_DEPTH = 2;

  // configuration port
  localparam int CFG_W      = 32;
  localparam int ADDR_W     = 3;
  localparam int CFG_WIN_W  = 11;
  localparam int CFG_MODE_W = 2;
  localparam logic [CFG_WIN_W-1:0] WINDOW_RESET = CFG_WIN_W'(5);

  typedef enum logic [0:0] {
    REG_WINDOW    = 1'b0,
    REG_EDGE_MODE = 1'b1
  } reg_idx_e;

  typedef enum logic [CFG_MODE_W-1:0] {
    EM_TRUNC     = 2'd0,
    EM_PAD_FIRST = 2'd1,
    EM_PAD_ZERO  = 2'd2
  } edge_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ACC,
    ST_PAD,
    ST_TOT,
    ST_DIV
  } back_state_e;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_ABS,
    DV_INIT,
    DV_ITER
  } div_state_e;

  // classified item handed from the front to the back
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic [TIME_W-1:0]          stamp;
    logic                       start;
    logic [WIN_W-1:0]           win;
    edge_mode_e                 mode;
  } token_t;

  typedef struct packed {
    logic              start;
    logic [SUM_W-1:0]  dividend;
    logic [WIN_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== hdl/moving_average_edge_modes.sv =====
// ----------------------------------------------------------------------------
// moving_average_edge_modes
// An item that yields a result passes the back-end states READ, ACC, PAD, TOT and
// DIV, with the 33-step quotient loop of the divider, then the output register; the
//   back end takes one item at a time; one that truncate mode holds back ends at PAD.
// A two-entry input queue keeps taking items while the back end works.
// Reset: rst_ni clears control, sum, count and pointers, and restores
//   window_length to 5 and edge_mode to truncate. The ring is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module moving_average_edge_modes import mae_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,   // sample_value[31:0], sample_time[95:32]
  input  logic              s_axis_tuser,   // series_start
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,   // average_value[31:0], average_time[95:32]
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [CFG_W-1:0]  pwdata,
  output logic [CFG_W-1:0]  prdata,
  output logic              pready
);

  logic [CFG_WIN_W-1:0]       window_q;
  logic [CFG_MODE_W-1:0]      mode_q;
  reg_idx_e                   reg_idx;
  logic                       cfg_wr;
  logic                       tok_valid, tok_pop;
  token_t                     tok;
  div_req_t                   div_req;
  div_status_t                div_stat;
  logic signed [SAMPLE_W-1:0] div_quot;
  logic signed [SAMPLE_W-1:0] avg_value;
  logic [TIME_W-1:0]          avg_time;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[ADDR_W-1]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
      mode_q   <= EM_TRUNC;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_WINDOW:    window_q <= pwdata[CFG_WIN_W-1:0];
        REG_EDGE_MODE: mode_q   <= pwdata[CFG_MODE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WINDOW:    prdata = CFG_W'(window_q);
      REG_EDGE_MODE: prdata = CFG_W'(mode_q);
    endcase
  end

  mae_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_value_i    (s_axis_tdata[SAMPLE_W-1:0]),
    .s_time_i     (s_axis_tdata[DATA_W-1:SAMPLE_W]),
    .s_start_i    (s_axis_tuser),
    .cfg_window_i (window_q),
    .cfg_mode_i   (mode_q),
    .tok_valid_o  (tok_valid),
    .tok_pop_i    (tok_pop),
    .tok_o        (tok)
  );

  mae_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .stat_o (div_stat),
    .quot_o (div_quot)
  );

  mae_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_valid),
    .tok_pop_o   (tok_pop),
    .tok_i       (tok),
    .div_req_o   (div_req),
    .div_stat_i  (div_stat),
    .div_quot_i  (div_quot),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_value_o   (avg_value),
    .m_time_o    (avg_time)
  );

  assign m_axis_tdata = {avg_time, avg_value};

endmodule

// ===== hdl/mae_ram.sv =====
// ----------------------------------------------------------------------------
// mae_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mae_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 1024,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/mae_front.sv =====
// ----------------------------------------------------------------------------
// mae_front
// Accepts input items, attaches the effective window and edge mode, and
// buffers them in a short queue for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mae_front import mae_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_valid_i,
  output logic                       s_ready_o,
  input  logic signed [SAMPLE_W-1:0] s_value_i,
  input  logic [TIME_W-1:0]          s_time_i,
  input  logic                       s_start_i,
  input  logic [CFG_WIN_W-1:0]       cfg_window_i,
  input  logic [CFG_MODE_W-1:0]      cfg_mode_i,
  output logic                       tok_valid_o,
  input  logic                       tok_pop_i,
  output token_t                     tok_o
);

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  function automatic logic [WIN_W-1:0] eff_window(input logic [CFG_WIN_W-1:0] len);
    if (len == '0) return WIN_W'(1);
    if (int'(len) > MAX_WINDOW) return WIN_W'(MAX_WINDOW);
    return WIN_W'(len);
  endfunction

  edge_mode_e        mode_cls;
  token_t            tok_in;
  token_t            slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push, pop;

  // unused mode code falls back to truncate
  always_comb begin
    unique case (cfg_mode_i)
      EM_PAD_FIRST: mode_cls = EM_PAD_FIRST;
      EM_PAD_ZERO:  mode_cls = EM_PAD_ZERO;
      default:      mode_cls = EM_TRUNC;
    endcase
  end

  always_comb begin
    tok_in.value = s_value_i;
    tok_in.stamp = s_time_i;
    tok_in.start = s_start_i;
    tok_in.win   = eff_window(cfg_window_i);
    tok_in.mode  = mode_cls;
  end

  assign s_ready_o   = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign tok_valid_o = (count_q != '0);
  assign push        = s_valid_i && s_ready_o;
  assign pop         = tok_pop_i && tok_valid_o;
  assign tok_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= tok_in;
    end
  end

endmodule

// ===== hdl/mae_div.sv =====
// ----------------------------------------------------------------------------
// mae_div
// Sequential signed divider: 64-bit sum by window length, truncated toward
// zero and saturated to the sample range, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mae_div import mae_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  div_req_t                   req_i,
  output div_status_t                stat_o,
  output logic signed [SAMPLE_W-1:0] quot_o
);

  localparam logic [QUO_W-1:0] NEG_LIMIT = QUO_W'(1) << (SAMPLE_W - 1);
  localparam logic [QUO_W-1:0] POS_LIMIT = NEG_LIMIT - 1'b1;

  div_state_e       state_q, state_d;
  logic [SUM_W-1:0] mag_q;
  logic             neg_q;
  logic             sat_q;
  logic [WIN_W-1:0] dvs_q;
  logic [WIN_W-1:0] rem_q;
  logic [QUO_W-1:0] dq_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic             last;
  logic [WIN_W:0]   trial;
  logic [WIN_W:0]   trial_sub;
  logic             ge;

  assign last      = (cnt_q == CNT_W'(QUO_W - 1));
  assign trial     = {rem_q, dq_q[QUO_W-1]};
  assign trial_sub = trial - {1'b0, dvs_q};
  assign ge        = (trial >= {1'b0, dvs_q});

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DV_IDLE: if (req_i.start) state_d = DV_ABS;
      DV_ABS:  state_d = DV_INIT;
      DV_INIT: state_d = DV_ITER;
      DV_ITER: if (last) state_d = DV_IDLE;
      default: state_d = DV_IDLE;
    endcase
  end

  always_comb begin
    stat_o.busy = (state_q != DV_IDLE);
    stat_o.done = done_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == DV_IDLE && req_i.start) begin
        done_q <= 1'b0;
      end else if (state_q == DV_ITER && last) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      DV_IDLE: begin
        if (req_i.start) begin
          mag_q <= req_i.dividend;
          neg_q <= req_i.dividend[SUM_W-1];
          dvs_q <= req_i.divisor;
        end
      end
      DV_ABS: begin
        if (neg_q) mag_q <= -mag_q;
      end
      DV_INIT: begin
        // high part at or above the divisor means the quotient overflows
        sat_q <= (mag_q[SUM_W-1:QUO_W] >= (SUM_W - QUO_W)'(dvs_q));
        rem_q <= mag_q[QUO_W+WIN_W-1:QUO_W];
        dq_q  <= mag_q[QUO_W-1:0];
        cnt_q <= '0;
      end
      DV_ITER: begin
        rem_q <= ge ? trial_sub[WIN_W-1:0] : trial[WIN_W-1:0];
        dq_q  <= {dq_q[QUO_W-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (neg_q) begin
      if (sat_q || dq_q > NEG_LIMIT) quot_o = NEG_LIMIT[SAMPLE_W-1:0];
      else                           quot_o = -dq_q[SAMPLE_W-1:0];
    end else begin
      if (sat_q || dq_q > POS_LIMIT) quot_o = POS_LIMIT[SAMPLE_W-1:0];
      else                           quot_o = dq_q[SAMPLE_W-1:0];
    end
  end

endmodule

// ===== hdl/mae_back.sv =====
// ----------------------------------------------------------------------------
// mae_back
// Executes one classified item at a time: series restart, ring update,
// running sum, edge padding, division launch and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "moving_average_edge_modes_macros.svh"

module mae_back import mae_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       tok_valid_i,
  output logic                       tok_pop_o,
  input  token_t                     tok_i,
  output div_req_t                   div_req_o,
  input  div_status_t                div_stat_i,
  input  logic signed [SAMPLE_W-1:0] div_quot_i,
  output logic                       m_valid_o,
  input  logic                       m_ready_i,
  output logic signed [SAMPLE_W-1:0] m_value_o,
  output logic [TIME_W-1:0]          m_time_o
);

  back_state_e                state_q, state_d;
  token_t                     cur_q;
  logic [SUM_W-1:0]           sum_q;
  logic [WIN_W-1:0]           seen_q;
  logic [PTR_W-1:0]           ptr_q;
  logic signed [SAMPLE_W-1:0] first_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_value_q;
  logic [TIME_W-1:0]          out_time_q;

  logic                ram_re, ram_we, out_load;
  logic [PTR_W-1:0]    ptr_base, rd_addr, ptr_nxt;
  logic [WIN_W:0]      ptr_ext, win_ext, rd_calc;
  logic [SAMPLE_W-1:0] ring_rdata;
  logic [SUM_W-1:0]    ring_ext, val_ext, pad_ext, sum_acc, total;
  logic [WIN_W-1:0]    seen_nxt, gap;
  logic                drop, short;

  // ring slot of the sample leaving the window
  assign ptr_base = cur_q.start ? '0 : ptr_q;
  assign ptr_ext  = (WIN_W + 1)'(ptr_base);
  assign win_ext  = (WIN_W + 1)'(cur_q.win);
  assign rd_calc  = (ptr_ext >= win_ext) ? ptr_ext - win_ext
                                         : ptr_ext + (WIN_W + 1)'(MAX_WINDOW) - win_ext;
  assign rd_addr  = rd_calc[PTR_W-1:0];

  assign ring_ext = {{(SUM_W - SAMPLE_W){ring_rdata[SAMPLE_W-1]}}, ring_rdata};
  assign val_ext  = {{(SUM_W - SAMPLE_W){cur_q.value[SAMPLE_W-1]}}, cur_q.value};
  assign drop     = (seen_q >= cur_q.win);
  assign sum_acc  = sum_q - (drop ? ring_ext : '0) + val_ext;
  assign ptr_nxt  = (ptr_q == PTR_W'(MAX_WINDOW - 1)) ? '0 : ptr_q + 1'b1;
  assign seen_nxt = (seen_q < WIN_W'(MAX_WINDOW)) ? seen_q + 1'b1 : seen_q;

  assign short    = (seen_q < cur_q.win);
  assign gap      = cur_q.win - seen_q;
  assign pad_ext  = {{(SUM_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign total    = sum_q + ((cur_q.mode == EM_PAD_FIRST && short) ? pad_ext : '0);

  mae_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptr_q),
    .wdata_i (cur_q.value),
    .re_i    (ram_re),
    .raddr_i (rd_addr),
    .rdata_o (ring_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (tok_valid_i) state_d = ST_READ;
      ST_READ: state_d = ST_ACC;
      ST_ACC:  state_d = ST_PAD;
      // truncate mode drops items until the window has filled
      ST_PAD:  state_d = (cur_q.mode == EM_TRUNC && short) ? ST_IDLE : ST_TOT;
      ST_TOT:  state_d = ST_DIV;
      ST_DIV:  if (div_stat_i.done && (!out_valid_q || m_ready_i)) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    tok_pop_o          = 1'b0;
    ram_re             = 1'b0;
    ram_we             = 1'b0;
    out_load           = 1'b0;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = total;
    div_req_o.divisor  = cur_q.win;
    unique case (state_q)
      ST_IDLE: tok_pop_o       = tok_valid_i;
      ST_READ: ram_re          = 1'b1;
      ST_ACC:  ram_we          = 1'b1;
      ST_TOT:  div_req_o.start = 1'b1;
      ST_DIV:  out_load        = div_stat_i.done && (!out_valid_q || m_ready_i);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
      seen_q      <= '0;
      ptr_q       <= '0;
      first_q     <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_READ && cur_q.start) begin
        sum_q   <= '0;
        seen_q  <= '0;
        ptr_q   <= '0;
        first_q <= cur_q.value;
      end else if (ram_we) begin
        sum_q  <= sum_acc;
        seen_q <= seen_nxt;
        ptr_q  <= ptr_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_pop_o) begin
      cur_q <= tok_i;
    end
    if (state_q == ST_PAD) begin
      prod_q <= $signed({1'b0, gap}) * first_q;
    end
    if (out_load) begin
      out_value_q <= div_quot_i;
      out_time_q  <= cur_q.stamp;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_value_o = out_value_q;
  assign m_time_o  = out_time_q;

  `MAE_ASSERT(a_acc_after_read, (state_q == ST_ACC) |-> ($past(state_q) == ST_READ), "ring update without a read")
  `MAE_ASSERT_NEXT(a_pop_then_read, tok_pop_o, state_q == ST_READ, "popped item not executed")
  `MAE_ASSERT(a_div_free, div_req_o.start |-> !div_stat_i.busy, "divider launched while busy")
  `MAE_ASSERT(a_ptr_tracks_seen, (seen_q < WIN_W'(MAX_WINDOW)) |-> (ptr_q == seen_q[PTR_W-1:0]), "ring pointer out of step")

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for moving_average_edge_modes. An in-bench tracker keeps
// its own ring, running sum, sample count and settings, predicts the average
// each sample should yield under the current window and edge mode, and
// compares it with what the stream output delivers. The stimulus runs a short
// directed set, several random series under random settings, and one long
// series under a large window. Sender and receiver both stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb import mae_pkg::*; ();

  localparam int unsigned LIMIT_CYCLES  = 1_000_000;
  localparam int          SETTLE_CYCLES = 160;    // room for held-back items
  localparam int          RANDOM_PHASES = 6;
  localparam int          PHASE_ITEMS   = 40;
  localparam int          LONG_SERIES   = 260;
  localparam logic [1:0]  MODE_SPARE    = 2'd3;   // undefined code, acts as truncate
  localparam logic [10:0] WIN_OVER_MAX  = 11'd2047;
  localparam logic signed [SAMPLE_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SAMPLE_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic [TIME_W-1:0]   stamp;
  } average_t;

  class average_tracker;
    logic signed [SAMPLE_W-1:0] ring [MAX_WINDOW];
    logic [63:0]                sum;
    int unsigned                seen;
    int unsigned                wr_ptr;
    logic signed [SAMPLE_W-1:0] first_val;
    logic [10:0]                win_reg;
    logic [1:0]                 mode_reg;
    average_t                   averages_due[$];
    int                         errors;

    function new();
      sum       = '0;
      seen      = 0;
      wr_ptr    = 0;
      first_val = '0;
      win_reg   = WINDOW_RESET;
      mode_reg  = EM_TRUNC;
      errors    = 0;
    endfunction

    function void report(string what);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    function void set_register(reg_idx_e idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_WINDOW:    win_reg  = v[10:0];
        REG_EDGE_MODE: mode_reg = v[1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return averages_due.size();
    endfunction

    function void take_sample(logic signed [SAMPLE_W-1:0] x, logic [TIME_W-1:0] t,
                              logic start);
      int unsigned         w;
      logic signed [63:0]  total;
      longint              q;
      logic signed [SAMPLE_W-1:0] old;
      average_t            e;
      if (start) begin
        sum       = '0;
        seen      = 0;
        wr_ptr    = 0;
        first_val = x;
      end
      w = (win_reg == 0) ? 1 : ((win_reg > MAX_WINDOW) ? MAX_WINDOW : win_reg);
      if (seen >= w) begin
        old = ring[(wr_ptr + MAX_WINDOW - w) % MAX_WINDOW];
        sum = sum - {{32{old[SAMPLE_W-1]}}, old};
      end
      sum = sum + {{32{x[SAMPLE_W-1]}}, x};
      ring[wr_ptr] = x;
      wr_ptr = (wr_ptr + 1) % MAX_WINDOW;
      if (seen < MAX_WINDOW) seen++;
      total = sum;
      if (mode_reg == EM_PAD_FIRST) begin
        if (seen < w) total = total + longint'(w - seen) * longint'(first_val);
      end else if (mode_reg != EM_PAD_ZERO && seen < w) begin
        return;
      end
      q = total / longint'(w);
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      e.value = q[SAMPLE_W-1:0];
      e.stamp = t;
      averages_due.insert(averages_due.size(), e);
    endfunction

    function void check_average(logic [SAMPLE_W-1:0] v, logic [TIME_W-1:0] t);
      average_t e;
      if (averages_due.size() == 0) begin
        report($sformatf("unexpected average %h time %h", v, t));
        return;
      end
      e = averages_due.pop_front();
      if (v !== e.value) report($sformatf("average_value %h, want %h", v, e.value));
      if (t !== e.stamp) report($sformatf("average_time %h, want %h", t, e.stamp));
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata  = '0;   // sample_value[31:0], sample_time[95:32]
  logic              s_axis_tuser  = 1'b0; // series_start
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;         // average_value[31:0], average_time[95:32]
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [ADDR_W-1:0] paddr         = '0;
  logic [CFG_W-1:0]  pwdata        = '0;
  logic [CFG_W-1:0]  prdata;
  logic              pready;

  average_tracker tracker = new();
  int             burst_left  = 0;
  int             hold_left   = 0;
  int unsigned    cycle_count = 0;

  moving_average_edge_modes DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("[moving_average_edge_modes] ERROR");
      $finish;
    end
  end

  // receiver: runs of ready and stall of random length
  always @(posedge clk_i) begin
    if (hold_left == 0) begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
      hold_left     <= $urandom_range(1, 60);
    end else begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      tracker.check_average(m_axis_tdata[SAMPLE_W-1:0], m_axis_tdata[DATA_W-1:SAMPLE_W]);
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x,
                             input logic [TIME_W-1:0] t, input logic start);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 2) != 0) gap = $urandom_range(1, 60);
    end
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {t, x};
    s_axis_tuser  <= start;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.take_sample(x, t, start);
    burst_left--;
  endtask

  // wait until every average has come and held-back items have cleared
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CFG_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.set_register(idx, v);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_value();
    case ($urandom_range(0, 11))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return '0;
      3:       return '1;
      4:       return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] rand_stamp();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [10:0] pick_window();
    case ($urandom_range(0, 13))
      0:       return '0;
      1:       return WIN_OVER_MAX;
      2:       return 11'(MAX_WINDOW);
      3, 4:    return 11'($urandom_range(11, 40));
      default: return 11'($urandom_range(1, 10));
    endcase
  endfunction

  initial begin
    int          n, len;
    bit          keep;
    logic [10:0] win;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // before any series start: pad-first pads with zero
    write_reg(REG_EDGE_MODE, CFG_W'(EM_PAD_FIRST));
    send_sample(Q_MAX, '0, 1'b0);
    send_sample(Q_MIN, '1, 1'b0);

    // truncate: nothing until the window of 5 is full, then the oldest drops
    drain();
    write_reg(REG_EDGE_MODE, CFG_W'(EM_TRUNC));
    send_sample('1, rand_stamp(), 1'b1);
    repeat (4) send_sample(Q_MAX, rand_stamp(), 1'b0);
    send_sample(Q_MIN, rand_stamp(), 1'b0);

    // zero length acts as one, spare mode acts as truncate
    drain();
    write_reg(REG_WINDOW, '0);
    write_reg(REG_EDGE_MODE, CFG_W'(MODE_SPARE));
    send_sample(Q_MIN, rand_stamp(), 1'b1);
    send_sample('1, rand_stamp(), 1'b0);

    // length above the ring size saturates, pad with zeros
    drain();
    write_reg(REG_WINDOW, CFG_W'(WIN_OVER_MAX));
    write_reg(REG_EDGE_MODE, CFG_W'(EM_PAD_ZERO));
    send_sample(Q_MAX, rand_stamp(), 1'b1);
    send_sample(-32'sd3, rand_stamp(), 1'b0);

    // shrink the window inside a series so the quotient clips high
    drain();
    write_reg(REG_WINDOW, CFG_W'(8));
    for (int i = 0; i < 8; i++) send_sample(Q_MAX, rand_stamp(), i == 0);
    drain();
    write_reg(REG_WINDOW, CFG_W'(1));
    send_sample(Q_MAX, rand_stamp(), 1'b0);

    // and low
    drain();
    write_reg(REG_WINDOW, CFG_W'(3));
    for (int i = 0; i < 3; i++) send_sample(Q_MIN, rand_stamp(), i == 0);
    drain();
    write_reg(REG_WINDOW, CFG_W'(1));
    send_sample(Q_MIN, rand_stamp(), 1'b0);

    // random settings; some phases keep the series across the change
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      win = pick_window();
      write_reg(REG_WINDOW, CFG_W'(win));
      write_reg(REG_EDGE_MODE, $urandom_range(0, 3));
      keep = ($urandom_range(0, 3) == 0);
      n = 0;
      while (n < PHASE_ITEMS) begin
        len = $urandom_range(1, (win > 18) ? 60 : 3 * win + 4);
        for (int i = 0; i < len; i++) begin
          send_sample(rand_value(), rand_stamp(),
                      (i == 0 && !keep) || ($urandom_range(0, 39) == 0));
          n++;
        end
        keep = 1'b0;
      end
    end

    // one long series: fills a large window and drops the oldest,
    // then changes length with the series kept
    drain();
    write_reg(REG_WINDOW, CFG_W'(256));
    write_reg(REG_EDGE_MODE, CFG_W'(EM_TRUNC));
    for (int i = 0; i < LONG_SERIES; i++) send_sample(rand_value(), rand_stamp(), i == 0);
    drain();
    write_reg(REG_WINDOW, CFG_W'(1000));
    write_reg(REG_EDGE_MODE, CFG_W'(EM_PAD_FIRST));
    repeat (20) send_sample(rand_value(), rand_stamp(), 1'b0);
    drain();
    write_reg(REG_WINDOW, CFG_W'(MAX_WINDOW));
    write_reg(REG_EDGE_MODE, CFG_W'(EM_PAD_ZERO));
    repeat (10) send_sample(rand_value(), rand_stamp(), 1'b0);

    drain();
    if (tracker.pending() != 0) tracker.report("averages still outstanding at end");
    if (tracker.errors == 0) begin
      $display("[moving_average_edge_modes] OK");
    end else begin
      $display("[moving_average_edge_modes] ERROR");
    end
    $finish;
  end

endmodule
